/* rtl/fir_convolution_filter_defines.svh */
// Assertion macros shared by the filter RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the using module.
`ifndef FIR_CONVOLUTION_FILTER_DEFINES_SVH
`define FIR_CONVOLUTION_FILTER_DEFINES_SVH

// Property checked at every edge outside reset.
`define FCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define FCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fcf_pkg.sv */
// Shared constants, types and width helpers for the FIR filter.
// No dependencies.
package fcf_pkg;

    localparam int TAPS_DEF        = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 24;

    localparam int IDX_W      = 10;
    localparam int GAIN_W     = 16;
    localparam int COEF_FRAC  = 12;
    localparam int GAIN_FRAC  = 12;
    localparam int COEF_RESET = 4194304;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    // accumulator width; wraps at 64 bits like a 64-bit sum
    function automatic int acc_width(int taps, int sb, int cb);
        int w;
        w = sb + cb + $clog2(taps);
        return (w > 64) ? 64 : w;
    endfunction

    // floor(log2(taps))
    function automatic int log2_floor(int taps);
        return $clog2(taps + 1) - 1;
    endfunction

endpackage

/* rtl/fcf_sdp_ram.sv */
// Simple dual-port RAM, one write port, one read port, registered read data.
// No dependencies.
module fcf_sdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fcf_mac.sv */
// Multiply-accumulate pipeline: registered product, then accumulator.
// Depends on fcf_pkg.
module fcf_mac #(
    parameter int TAPS        = fcf_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = fcf_pkg::COEF_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fcf_pkg::t_mac_ctl    i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_hist,
    input  logic [COEF_BITS-1:0] i_coef,
    output logic [fcf_pkg::acc_width(TAPS, SAMPLE_BITS, COEF_BITS)-1:0] o_acc,
    output logic                 o_done
);

    localparam int ACC_W  = fcf_pkg::acc_width(TAPS, SAMPLE_BITS, COEF_BITS);
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v;
    logic                     r_first;
    logic                     r_last;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_hist) * $signed(i_coef);
        if (r_v) begin
            r_acc <= r_first ? prod_ext : r_acc + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_first <= 1'b0;
            r_last  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_v     <= i_ctl.valid;
            r_first <= i_ctl.first;
            r_last  <= i_ctl.last;
            r_done  <= r_v & r_last;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

/* rtl/fcf_post.sv */
// Output scaling: tap-count shift, gain multiply in two partial products,
// fraction shift, saturation and the output register. Depends on fcf_pkg.
module fcf_post #(
    parameter int TAPS        = fcf_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = fcf_pkg::COEF_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [fcf_pkg::acc_width(TAPS, SAMPLE_BITS, COEF_BITS)-1:0] i_acc,
    input  logic [fcf_pkg::GAIN_W-1:0] i_gain,
    output logic                 o_done,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic                 o_sat
);

    localparam int ACC_W = fcf_pkg::acc_width(TAPS, SAMPLE_BITS, COEF_BITS);
    localparam int L     = fcf_pkg::log2_floor(TAPS);
    localparam int TW    = ACC_W - L;
    localparam int LO_W  = (TW + 1) / 2;
    localparam int HI_W  = TW - LO_W;
    localparam int PL_W  = LO_W + fcf_pkg::GAIN_W;
    localparam int PH_W  = HI_W + fcf_pkg::GAIN_W + 1;
    localparam int PW    = (TW + fcf_pkg::GAIN_W + 1 > 64) ? 64 : TW + fcf_pkg::GAIN_W + 1;
    localparam int SH    = fcf_pkg::COEF_FRAC + fcf_pkg::GAIN_FRAC;
    localparam int QW    = PW - SH;

    logic [LO_W-1:0]                 t_lo;
    logic signed [HI_W-1:0]          t_hi;
    logic signed [fcf_pkg::GAIN_W:0] gain_s;
    logic [PL_W-1:0]                 r_pl;
    logic signed [PH_W-1:0]          r_ph;
    logic [PW-1:0]                   ph_ext;
    logic [PW-1:0]                   pl_ext;
    logic [PW-1:0]                   r_prod;
    logic                            r_va;
    logic                            r_vb;
    logic [QW-1:0]                   q;
    logic [QW-SAMPLE_BITS:0]         q_top;
    logic                            ovf;
    logic [SAMPLE_BITS-1:0]          res;
    logic                            load;
    logic                            r_m_valid;
    logic [SAMPLE_BITS-1:0]          r_sample;
    logic                            r_sat;

    assign t_lo   = i_acc[L+LO_W-1:L];
    assign t_hi   = i_acc[ACC_W-1:L+LO_W];
    assign gain_s = {1'b0, i_gain};

    assign ph_ext = PW'(r_ph);
    assign pl_ext = PW'(r_pl);

    // arithmetic shift by the fraction bits, then clip
    assign q     = r_prod[PW-1:SH];
    assign q_top = q[QW-1:SAMPLE_BITS-1];
    assign ovf   = !((&q_top) || !(|q_top));
    always_comb begin
        res = q[SAMPLE_BITS-1:0];
        if (ovf) begin
            res = q[QW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign load = r_vb && (!r_m_valid || i_m_ready);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pl <= t_lo * i_gain;
            r_ph <= t_hi * gain_s;
        end
        if (r_va) begin
            r_prod <= (ph_ext << LO_W) + pl_ext;
        end
        if (load) begin
            r_sample <= res;
            r_sat    <= ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va      <= 1'b0;
            r_vb      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_va <= i_start;
            if (r_va) begin
                r_vb <= 1'b1;
            end else if (load) begin
                r_vb <= 1'b0;
            end
            if (load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_done    = load;
    assign o_m_valid = r_m_valid;
    assign o_sample  = r_sample;
    assign o_sat     = r_sat;

endmodule

/* rtl/fir_convolution_filter.sv */
// FIR filter over TAPS taps: item sequencer, coefficient and history memories,
// MAC pipeline and output scaling.
// Depends on fcf_pkg, fcf_sdp_ram, fcf_mac, fcf_post and the defines header.
//
// Usage:
//   s channel: tuser[0] is the opcode (0 filter a sample, 1 load a coefficient).
//   A load item writes one tap in the cycle it is accepted and gives no result;
//   an index at or beyond TAPS is dropped. A filter item writes the sample into
//   the history ring and gives one result on the m channel. The coefficient
//   walk through the memories runs one tap per cycle; the next item is
//   accepted in the cycle after the result is loaded.
//   cfg channel: writes the Q4.12 gain; always ready, write it while idle.
//   Reset: a clearing pass over every tap loads the unit impulse into the
//   coefficient memory and zeros into the history; s_tready stays low.
//   Stall: one result waits in the output register while the next item is
//   taken; if it is still not taken, the next result holds in the scaler.
`include "fir_convolution_filter_defines.svh"

module fir_convolution_filter #(
    parameter int TAPS        = fcf_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = fcf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = fcf_pkg::COEF_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // tap_index, sample_in, coefficient_in, zero pad
    input  logic [((fcf_pkg::IDX_W+SAMPLE_BITS+COEF_BITS+7)/8)*8-1:0] i_s_tdata,
    // opcode
    input  logic [0:0] i_s_tuser,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // sample_out, zero pad
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] o_m_tdata,
    // saturated
    output logic [0:0] o_m_tuser,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [fcf_pkg::GAIN_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(TAPS);
    localparam int IW    = fcf_pkg::IDX_W;
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ACC_W = fcf_pkg::acc_width(TAPS, SAMPLE_BITS, COEF_BITS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_MAC   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [AW-1:0]              r_tap;
    logic [AW-1:0]              n_tap;
    logic [AW-1:0]              r_hrd;
    logic [AW-1:0]              n_hrd;
    logic [AW-1:0]              r_ptr;
    logic [AW-1:0]              n_ptr;
    logic [fcf_pkg::GAIN_W-1:0] r_gain;
    fcf_pkg::t_mac_ctl          r_ctl;
    fcf_pkg::t_mac_ctl          n_ctl;

    logic [IW-1:0]          tap_index;
    logic [SAMPLE_BITS-1:0] sample_in;
    logic [COEF_BITS-1:0]   coefficient_in;
    logic                   s_acc;
    logic                   idx_ok;

    logic                   hist_we;
    logic [AW-1:0]          hist_waddr;
    logic [SAMPLE_BITS-1:0] hist_wdata;
    logic [SAMPLE_BITS-1:0] hist_rdata;
    logic                   coef_we;
    logic [AW-1:0]          coef_waddr;
    logic [COEF_BITS-1:0]   coef_wdata;
    logic [COEF_BITS-1:0]   coef_rdata;

    logic [ACC_W-1:0]       mac_acc;
    logic                   mac_done;
    logic                   post_done;
    logic [SAMPLE_BITS-1:0] post_sample;
    logic                   post_sat;

    assign tap_index      = i_s_tdata[IW-1:0];
    assign sample_in      = i_s_tdata[IW+SAMPLE_BITS-1:IW];
    assign coefficient_in = i_s_tdata[IW+SAMPLE_BITS+COEF_BITS-1:IW+SAMPLE_BITS];

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign idx_ok     = 32'(tap_index) < TAPS;

    // memory write ports: clearing pass or accepted item
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = r_ptr;
        hist_wdata = sample_in;
        coef_we    = 1'b0;
        coef_waddr = AW'(tap_index);
        coef_wdata = coefficient_in;
        if (r_state == ST_CLEAR) begin
            hist_we    = 1'b1;
            hist_waddr = r_tap;
            hist_wdata = '0;
            coef_we    = 1'b1;
            coef_waddr = r_tap;
            coef_wdata = (r_tap == '0) ? COEF_BITS'(fcf_pkg::COEF_RESET) : '0;
        end else if (s_acc) begin
            hist_we = (i_s_tuser[0] == fcf_pkg::OP_FILTER);
            coef_we = (i_s_tuser[0] == fcf_pkg::OP_LOAD) && idx_ok;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        n_hrd   = r_hrd;
        n_ptr   = r_ptr;
        n_ctl   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                n_tap = r_tap + 1'b1;
                if (r_tap == LAST_TAP) begin
                    n_tap   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc && (i_s_tuser[0] == fcf_pkg::OP_FILTER)) begin
                    n_hrd   = r_ptr;
                    n_ptr   = (r_ptr == LAST_TAP) ? '0 : r_ptr + 1'b1;
                    n_tap   = '0;
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                n_ctl.valid = 1'b1;
                n_ctl.first = (r_tap == '0);
                n_ctl.last  = (r_tap == LAST_TAP);
                n_tap       = r_tap + 1'b1;
                n_hrd       = (r_hrd == '0) ? LAST_TAP : r_hrd - 1'b1;
                if (r_tap == LAST_TAP) begin
                    n_tap   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (post_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_tap   <= '0;
            r_hrd   <= '0;
            r_ptr   <= '0;
            r_ctl   <= '0;
            r_gain  <= fcf_pkg::GAIN_RESET;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_hrd   <= n_hrd;
            r_ptr   <= n_ptr;
            r_ctl   <= n_ctl;
            if (i_cfg_valid) begin
                r_gain <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    fcf_sdp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (r_hrd),
        .o_rdata (hist_rdata)
    );

    fcf_sdp_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (r_tap),
        .o_rdata (coef_rdata)
    );

    fcf_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_hist  (hist_rdata),
        .i_coef  (coef_rdata),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    fcf_post #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mac_done),
        .i_acc     (mac_acc),
        .i_gain    (r_gain),
        .o_done    (post_done),
        .o_m_valid (o_m_tvalid),
        .i_m_ready (i_m_tready),
        .o_sample  (post_sample),
        .o_sat     (post_sat)
    );

    assign o_m_tdata    = OUT_W'(post_sample);
    assign o_m_tuser[0] = post_sat;

    `FCF_ASSERT(a_mac_done_drain, mac_done |-> (r_state == ST_DRAIN), "MAC done outside drain")
    `FCF_ASSERT(a_no_hist_wr_mac, (r_state == ST_MAC) |-> !hist_we, "history write during MAC")
    `FCF_ASSERT_NEXT(a_ring_start, s_acc && (i_s_tuser[0] == fcf_pkg::OP_FILTER), (r_state == ST_MAC) && (r_hrd == $past(r_ptr)), "ring read start wrong")
    `FCF_ASSERT_NEXT(a_post_idle, post_done, r_state == ST_IDLE, "no return to idle after result")

endmodule
